>>> sv/mqrb_pkg.sv
// Shared types, codes and default sizes for the multi-queue ring buffer.
package mqrb_pkg;

	// Default build sizes
	localparam int NUM_QUEUES_DEF = 32;
	localparam int MAX_DEPTH_DEF  = 128;
	localparam int DATA_WIDTH_DEF = 64;

	// Depth after reset
	localparam int RESET_DEPTH = 8;

	// Request kinds
	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic        req_type;
		logic [4:0]  queue_index;
		logic [63:0] entry_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] read_data;
		logic [7:0]  occupancy;
	} rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic cap_req;    // capture the accepted request
		logic exec;       // update pointers, access the slot memory
		logic load_fast;  // load the result register from the update path
		logic load_read;  // load the result register from the memory read
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic deq_hit;    // captured request is a dequeue that will read a slot
	} dp_stat_t;

endpackage

>>> sv/mqrb_ctrl.sv
// Sequencing controller for the multi-queue ring buffer.
module mqrb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  mqrb_pkg::dp_stat_t stat,
	output mqrb_pkg::cmd_t    cmd
);
	import mqrb_pkg::*;

	state_t state_q, state_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.cap_req = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.deq_hit) begin
					cmd.exec = 1'b1;
					state_d  = S_READ;
				end else if (out_free) begin
					cmd.exec      = 1'b1;
					cmd.load_fast = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_READ: begin
				if (out_free) begin
					cmd.load_read = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the result until taken; raise when a new result loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_fast || cmd.load_read) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

>>> sv/mqrb_datapath.sv
// Queue pointers, slot memory, depth register and result register.
module mqrb_datapath #(
	parameter int NUM_QUEUES = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int MAX_DEPTH  = mqrb_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = mqrb_pkg::DATA_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mqrb_pkg::req_t     req,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_data,
	input  mqrb_pkg::cmd_t     cmd,
	output mqrb_pkg::dp_stat_t stat,
	output mqrb_pkg::rsp_t     rsp
);
	import mqrb_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int AW = QW + PW;
	localparam int MEM_DEPTH = 1 << AW;
	localparam int RST_D = (MAX_DEPTH < RESET_DEPTH) ? MAX_DEPTH : RESET_DEPTH;

	logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];

	logic [PW-1:0] head_q [NUM_QUEUES];
	logic [PW-1:0] tail_q [NUM_QUEUES];
	logic [CW-1:0] fill_q [NUM_QUEUES];
	logic [CW-1:0] depth_q;

	req_t                  req_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [7:0]            pend_occ_q;
	rsp_t                  rsp_q;

	logic          q_ok, is_deq, enq_ok, deq_ok;
	logic [QW-1:0] q_idx;
	logic [CW-1:0] cnt, cnt_nxt;
	logic [PW-1:0] ptr, ptr_nxt;
	logic [CW:0]   ptr_inc;
	logic [AW-1:0] addr;
	logic [1:0]    res_status;
	logic [7:0]    res_occ;
	logic [CW-1:0] cfg_depth;

	// Clamp the written depth into one to MAX_DEPTH.
	always_comb begin
		if (cfg_data == 8'd0) begin
			cfg_depth = CW'(1);
		end else if (int'(cfg_data) > MAX_DEPTH) begin
			cfg_depth = CW'(MAX_DEPTH);
		end else begin
			cfg_depth = CW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= CW'(RST_D);
		end else if (cfg_we) begin
			depth_q <= cfg_depth;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_req) begin
			req_q <= req;
		end
	end

	assign q_idx  = QW'(req_q.queue_index);
	assign q_ok   = int'(req_q.queue_index) < NUM_QUEUES;
	assign is_deq = (req_q.req_type == REQ_DEQ);
	assign cnt    = fill_q[q_idx];
	assign enq_ok = q_ok && !is_deq && (cnt < depth_q);
	assign deq_ok = q_ok && is_deq && (cnt != '0);
	assign ptr    = is_deq ? head_q[q_idx] : tail_q[q_idx];
	assign addr   = {q_idx, ptr};

	// Advance one slot, wrap at the depth in use.
	assign ptr_inc = (CW + 1)'(ptr) + 1'b1;
	assign ptr_nxt = (ptr_inc >= {1'b0, depth_q}) ? '0 : PW'(ptr_inc);

	always_comb begin
		cnt_nxt = cnt;
		if (enq_ok) begin
			cnt_nxt = cnt + 1'b1;
		end else if (deq_ok) begin
			cnt_nxt = cnt - 1'b1;
		end
	end

	assign res_status = (enq_ok || deq_ok) ? ST_DONE : (is_deq ? ST_EMPTY : ST_FULL);
	assign res_occ    = q_ok ? 8'(cnt_nxt) : 8'd0;
	assign stat.deq_hit = deq_ok;

	// Pointers and counts; a depth write empties every queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.exec && (enq_ok || deq_ok)) begin
			fill_q[q_idx] <= cnt_nxt;
			if (enq_ok) begin
				tail_q[q_idx] <= ptr_nxt;
			end else begin
				head_q[q_idx] <= ptr_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec && enq_ok) begin
			mem[addr] <= req_q.entry_data[DATA_WIDTH-1:0];
		end
		if (cmd.exec && deq_ok) begin
			rdata_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pend_occ_q <= res_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_fast) begin
			rsp_q.status    <= res_status;
			rsp_q.read_data <= '0;
			rsp_q.occupancy <= res_occ;
		end else if (cmd.load_read) begin
			rsp_q.status    <= ST_DONE;
			rsp_q.read_data <= 64'(rdata_q);
			rsp_q.occupancy <= pend_occ_q;
		end
	end

	assign rsp = rsp_q;

endmodule

>>> sv/multi_queue_ring_buffer_unit.sv
// Top level of the multi-queue ring buffer: bank of circular FIFOs sharing one depth.
//
//   channel  signals                     direction  moves
//   req      req_valid, req_stall, req   in         one enqueue or dequeue request
//   rsp      rsp_valid, rsp_stall, rsp   out        status, read word, occupancy
//   cfg      cfg_valid, cfg_ready, cfg_data  in     queue depth register write
//
// The result loads from the update path once its request is captured; a successful
// dequeue then waits in S_READ for the registered read port of the slot memory.
// The next request is taken only after the result of the last one loads.
// Reset empties every queue and sets the depth to 8; slot contents are not cleared.
// A stall on rsp holds the waiting result; one more request is still captured, but
// its result and every later request wait until the held result is taken.
module multi_queue_ring_buffer_unit #(
	parameter int NUM_QUEUES = mqrb_pkg::NUM_QUEUES_DEF,
	parameter int MAX_DEPTH  = mqrb_pkg::MAX_DEPTH_DEF,
	parameter int DATA_WIDTH = mqrb_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           req_valid,
	output logic           req_stall,
	input  mqrb_pkg::req_t req,
	// result channel
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output mqrb_pkg::rsp_t rsp,
	// depth register write channel
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [7:0]     cfg_data
);
	import mqrb_pkg::*;

	cmd_t     cmd;
	dp_stat_t stat;
	logic     cfg_we;

	// Always ready; the user must write only while the block is idle (unchecked).
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequence each transaction: capture, update, then an optional memory read.
	mqrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Hold pointers, counts and slots; build the result word.
	mqrb_datapath #(
		.NUM_QUEUES (NUM_QUEUES),
		.MAX_DEPTH  (MAX_DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

>>> bench/tb_multi_queue_ring_buffer_unit.sv
// Self-checking testbench for the multi-queue ring buffer unit.
module tb_multi_queue_ring_buffer_unit;
	import mqrb_pkg::*;

	localparam int NQ         = NUM_QUEUES_DEF;
	localparam int DEPTH_MAX  = MAX_DEPTH_DEF;
	localparam int QUIET_MAX  = 5000;   // cycles without any transaction before giving up
	localparam int MIX_ITEMS  = 50;     // random mixed requests per depth setting
	localparam int NUM_PHASES = 9;

	// One row of the directed sequence; typed rows carry their own expected result.
	typedef struct packed {
		logic        req_type;
		logic [4:0]  queue_index;
		logic [63:0] entry_data;
		logic        typed;
		rsp_t        want;
	} dir_row_t;

	// Directed sequence at the reset depth of 8: empty queues, data extremes on the
	// first and last queue, fill one queue to full, drain it past the wrap, refill.
	localparam dir_row_t DIR_ROWS [0:24] = '{
		'{REQ_DEQ, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_EMPTY, 64'd0, 8'd0}},
		'{REQ_DEQ, 5'd31, 64'd0,                   1'b1, '{ST_EMPTY, 64'd0, 8'd0}},
		'{REQ_ENQ, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{ST_DONE,  64'd0, 8'd1}},
		'{REQ_ENQ, 5'd0,  64'd0,                   1'b1, '{ST_DONE,  64'd0, 8'd1}},
		'{REQ_DEQ, 5'd31, 64'd0,                   1'b1,
			'{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0}},
		'{REQ_DEQ, 5'd0,  64'h1234_5678_9ABC_DEF0, 1'b1, '{ST_DONE,  64'd0, 8'd0}},
		'{REQ_ENQ, 5'd5,  64'h8000_0000_0000_0001, 1'b1, '{ST_DONE,  64'd0, 8'd1}},
		'{REQ_ENQ, 5'd5,  64'h5555_5555_5555_5555, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'h0123_4567_89AB_CDEF, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'hFEDC_BA98_7654_3210, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0},
		'{REQ_ENQ, 5'd5,  64'hDEAD_BEEF_DEAD_BEEF, 1'b1, '{ST_FULL,  64'd0, 8'd8}},
		'{REQ_DEQ, 5'd5,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
			'{ST_DONE, 64'h8000_0000_0000_0001, 8'd7}},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b0, '0},
		'{REQ_DEQ, 5'd5,  64'd0,                   1'b1, '{ST_EMPTY, 64'd0, 8'd0}},
		'{REQ_ENQ, 5'd5,  64'hC3C3_3C3C_C3C3_3C3C, 1'b0, '0}
	};

	// Depth settings walked by the random part; the last phase draws its own.
	localparam logic [7:0] PHASE_DEPTHS [0:7] = '{
		8'd1, 8'd0, 8'd2, 8'd3, 8'd128, 8'd255, 8'd16, 8'd8
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       req_valid;
	logic       req_stall;
	req_t       req;
	logic       rsp_valid;
	logic       rsp_stall;
	rsp_t       rsp;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	multi_queue_ring_buffer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	// Mirror of the FIFO bank: slot words, wrapped pointers and fill counts per queue.
	logic [63:0] slot_words [NQ][DEPTH_MAX];
	int          head_ptr [NQ];
	int          tail_ptr [NQ];
	int          fill_cnt [NQ];
	logic [7:0]  depth_reg;

	rsp_t pending_rsp [$];   // results still owed by the block, oldest first

	int send_idle_pct;
	int rcv_stall_pct;
	int reqs_sent;
	int rsps_seen;
	int full_answers;
	int empty_answers;
	int depth_writes;
	int mismatch_cnt;
	int stray_cnt;
	int report_cnt;
	int quiet_cycles;

	// Depth in force: zero acts as one, anything above the built maximum is clamped.
	function automatic int depth_in_force();
		if (depth_reg == 8'd0)
			return 1;
		if (int'(depth_reg) > DEPTH_MAX)
			return DEPTH_MAX;
		return int'(depth_reg);
	endfunction

	// Apply one request to the mirror and return the result the block owes for it.
	// A 5-bit queue index cannot leave the 32-queue range, so no out-of-range path here.
	function automatic rsp_t fifo_bank_step(req_t r);
		rsp_t res;
		int   q;
		int   d;
		res = '0;
		q   = int'(r.queue_index);
		d   = depth_in_force();
		if (r.req_type == REQ_ENQ) begin
			if (fill_cnt[q] >= d) begin
				res.status = ST_FULL;
				full_answers++;
			end else begin
				slot_words[q][tail_ptr[q]] = r.entry_data;
				tail_ptr[q] = (tail_ptr[q] + 1 >= d) ? 0 : tail_ptr[q] + 1;
				fill_cnt[q]++;
				res.status = ST_DONE;
			end
		end else begin
			if (fill_cnt[q] == 0) begin
				res.status = ST_EMPTY;
				empty_answers++;
			end else begin
				res.read_data = slot_words[q][head_ptr[q]];
				head_ptr[q] = (head_ptr[q] + 1 >= d) ? 0 : head_ptr[q] + 1;
				fill_cnt[q]--;
				res.status = ST_DONE;
			end
		end
		res.occupancy = 8'(fill_cnt[q]);
		return res;
	endfunction

	// Drive one request transaction, with random idle cycles ahead of it per the
	// current sender setting. Valid stays high across back-to-back transactions.
	task automatic issue_req(input req_t r, input logic typed, input rsp_t typed_rsp);
		rsp_t model_rsp;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_valid = 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		req       = r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		// Accepted at this edge: advance the mirror and queue the owed result.
		model_rsp = fifo_bank_step(r);
		pending_rsp.push_back(typed ? typed_rsp : model_rsp);
		reqs_sent++;
	endtask

	// Hold off new requests until every owed result has been taken.
	task automatic wait_rsp_drain();
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Write the depth register with the block idle; the write empties every queue.
	task automatic write_queue_depth(input logic [7:0] value);
		wait_rsp_drain();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		depth_reg = value;
		for (int q = 0; q < NQ; q++) begin
			head_ptr[q] = 0;
			tail_ptr[q] = 0;
			fill_cnt[q] = 0;
		end
		depth_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result checker: take each accepted result transaction against the oldest owed one.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsps_seen++;
			if (pending_rsp.size() == 0) begin
				stray_cnt++;
				if (report_cnt < 10) begin
					report_cnt++;
					$display("[%0t] unexpected result: status=%0d data=%h occ=%0d",
						$realtime, rsp.status, rsp.read_data, rsp.occupancy);
				end
			end else begin
				want = pending_rsp.pop_front();
				if (want.status !== rsp.status || want.read_data !== rsp.read_data ||
					want.occupancy !== rsp.occupancy) begin
					mismatch_cnt++;
					if (report_cnt < 10) begin
						report_cnt++;
						$display("[%0t] result %0d mismatch: status exp %0d got %0d",
							$realtime, rsps_seen, want.status, rsp.status);
						$display("    read_data exp %h got %h, occupancy exp %0d got %0d",
							want.read_data, rsp.read_data, want.occupancy, rsp.occupancy);
					end
				end
			end
		end
	end

	// Receiver: stall at random per the current setting, changed on the falling edge.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
	end

	// Watchdog: count cycles in which no transaction moves on any channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_MAX) begin
			$display("watchdog: %0d cycles without a transaction, %0d results owed",
				quiet_cycles, pending_rsp.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		req_t       r;
		int         d;
		int         fill_q;
		int         pool [2];
		logic       use_pool;
		int         enq_pct;
		logic [7:0] depth_val;

		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 8'd0;
		send_idle_pct = 0;
		rcv_stall_pct = 0;
		reqs_sent     = 0;
		rsps_seen     = 0;
		full_answers  = 0;
		empty_answers = 0;
		depth_writes  = 0;
		mismatch_cnt  = 0;
		stray_cnt     = 0;
		report_cnt    = 0;
		quiet_cycles  = 0;
		depth_reg     = 8'(RESET_DEPTH);
		for (int q = 0; q < NQ; q++) begin
			head_ptr[q] = 0;
			tail_ptr[q] = 0;
			fill_cnt[q] = 0;
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed sequence at the reset depth, no idling.
		for (int i = 0; i < 25; i++) begin
			r.req_type    = DIR_ROWS[i].req_type;
			r.queue_index = DIR_ROWS[i].queue_index;
			r.entry_data  = DIR_ROWS[i].entry_data;
			issue_req(r, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end

		// Random part: one depth setting per phase, idling mode rotating through
		// none, sender idle, receiver stall and both.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			depth_val = (ph < 8) ? PHASE_DEPTHS[ph] : 8'($urandom_range(127, 4));
			write_queue_depth(depth_val);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 59;
					rcv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rcv_stall_pct = 59;
				end
				default: begin
					send_idle_pct = 19;
					rcv_stall_pct = 19;
				end
			endcase

			// Fill one queue past full, then drain it past empty, random words.
			d      = depth_in_force();
			fill_q = $urandom_range(NQ - 1);
			for (int i = 0; i < d + 2; i++) begin
				r.req_type    = REQ_ENQ;
				r.queue_index = 5'(fill_q);
				r.entry_data  = {$urandom, $urandom};
				issue_req(r, 1'b0, '0);
			end
			for (int i = 0; i < d + 2; i++) begin
				r.req_type    = REQ_DEQ;
				r.queue_index = 5'(fill_q);
				r.entry_data  = {$urandom, $urandom};
				issue_req(r, 1'b0, '0);
			end

			// Mixed traffic: lean toward enqueues first, dequeues later, sometimes
			// confined to two queues so that full and empty come up often.
			use_pool = 1'($urandom_range(1));
			pool[0]  = $urandom_range(NQ - 1);
			pool[1]  = $urandom_range(NQ - 1);
			for (int i = 0; i < MIX_ITEMS; i++) begin
				// Pause the sender once per phase until all owed results are in.
				if (i == MIX_ITEMS / 2)
					wait_rsp_drain();
				enq_pct       = (i < MIX_ITEMS / 2) ? 65 : 35;
				r.req_type    = ($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
				r.queue_index = use_pool ? 5'(pool[$urandom_range(1)]) : 5'($urandom_range(NQ - 1));
				r.entry_data  = {$urandom, $urandom};
				issue_req(r, 1'b0, '0);
			end
		end

		// Drop valid, collect what is still owed, then let the pipeline settle.
		wait_rsp_drain();
		rcv_stall_pct = 0;
		repeat (8) @(posedge clk);

		$display("Covered %0d requests and %0d results over %0d depth writes",
			reqs_sent, rsps_seen, depth_writes);
		$display("Refused enqueues on full queues: %0d, dequeues on empty queues: %0d",
			full_answers, empty_answers);
		if (mismatch_cnt == 0 && stray_cnt == 0 && pending_rsp.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d unexpected results, %0d results missing",
				mismatch_cnt, stray_cnt, pending_rsp.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/mqrb_pkg.sv
sv/mqrb_ctrl.sv
sv/mqrb_datapath.sv
sv/multi_queue_ring_buffer_unit.sv
bench/tb_multi_queue_ring_buffer_unit.sv
